FILE: src/rc4_pkg.sv
// Shared widths, types and codes for the RC4 stream cipher block.
package rc4_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PERM_SIZE = 256;
  localparam int unsigned KEY_LEN_W = 9;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KEY_LEN_W-1:0] key_len_t;

  // tuser codes on the input side
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

endpackage : rc4_pkg

FILE: src/rc4_stream_cipher.sv
// RC4 stream cipher core: key store, key schedule sequencer and keystream unit.
//
// RC4 byte cipher; encryption and decryption are the same operation. Send key
// bytes with tuser = 0; the beat with tlast set ends the key and starts the key
// schedule. Key bytes beyond KEY_BYTES_MAX are dropped, though a tlast on a
// dropped byte still ends the key. Send data bytes with tuser = 1; each gives
// one output beat holding the byte XOR the next keystream byte, with tlast
// copied through to mark the end of a message. The first data byte after a
// message end reruns the key schedule from the stored key, so every message
// starts a fresh keystream. Data sent before a key is complete (or while a new
// key is arriving) passes through unchanged with the output tuser (not_keyed)
// set. A pass-through byte, or a key byte without tlast, leaves the core idle.
// A keyed data byte is accepted, then takes four accesses of the one-read,
// one-write permutation memory: read S[i], read S[j], write S[i] with read
// S[t], write S[j]. The key schedule first loads the identity permutation
// into all 256 entries, then does 256 swap steps (states K_RD, K_ACC, K_WA,
// K_WB) on the same memory. It runs after the final key byte and ahead of
// the first data byte of every later message; the input is not ready
// meanwhile. The input is also held off while a result waits on the output.
module rc4_stream_cipher #(
  parameter int unsigned KEY_BYTES_MAX = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  rc4_pkg::byte_t s_axis_tdata_i,   // [7:0] byte_in
  input  logic          s_axis_tuser_i,    // [0] mode (0 key, 1 data)
  input  logic          s_axis_tlast_i,    // last key byte / last message byte
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output rc4_pkg::byte_t m_axis_tdata_o,   // [7:0] byte_out
  output logic          m_axis_tuser_o,    // [0] not_keyed
  output logic          m_axis_tlast_o     // message_end
);
  import rc4_pkg::*;

  localparam int unsigned KW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_K_RD  = 4'd2;
  localparam logic [3:0] ST_K_ACC = 4'd3;
  localparam logic [3:0] ST_K_WA  = 4'd4;
  localparam logic [3:0] ST_K_WB  = 4'd5;
  localparam logic [3:0] ST_D_RI  = 4'd6;
  localparam logic [3:0] ST_D_RJ  = 4'd7;
  localparam logic [3:0] ST_D_WI  = 4'd8;
  localparam logic [3:0] ST_D_WJ  = 4'd9;

  // memories
  byte_t perm_mem [PERM_SIZE];
  byte_t key_mem  [KEY_BYTES_MAX];

  byte_t   perm_rd_q, key_rd_q;
  byte_t   perm_raddr, perm_waddr, perm_wdata;
  logic    perm_we;
  logic [KW-1:0] key_waddr;
  logic    key_we;

  // control and datapath registers
  logic [3:0] state_q, state_d;
  key_len_t key_len_q, key_len_d;
  logic     keyed_q, keyed_d;
  logic     resched_q, resched_d;
  logic     loading_q, loading_d;
  logic     for_data_q, for_data_d;
  byte_t    n_q, n_d;
  logic [KW-1:0] kidx_q, kidx_d;
  byte_t    acc_q, acc_d;
  byte_t    sn_q, sn_d;
  byte_t    i_q, i_d, j_q, j_d;
  byte_t    si_q, si_d, sj_q, sj_d, t_q, t_d;
  byte_t    byte_q, byte_d;
  logic     last_q, last_d;
  logic     out_valid_q, out_valid_d;
  byte_t    out_data_q, out_data_d;
  logic     out_nk_q, out_nk_d;
  logic     out_last_q, out_last_d;

  logic     in_fire;
  key_len_t len_cur;
  byte_t    acc_sum, j_sum, t_sum, ks;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_nk_q;
  assign m_axis_tlast_o  = out_last_q;

  // a new key restarts the length count
  assign len_cur = loading_q ? key_len_q : '0;
  assign acc_sum = acc_q + perm_rd_q + key_rd_q;
  assign j_sum   = j_q + perm_rd_q;
  assign t_sum   = si_q + perm_rd_q;
  // bypass the swap written around the keystream read
  assign ks = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : perm_rd_q);

  always_comb begin
    state_d     = state_q;
    key_len_d   = key_len_q;
    keyed_d     = keyed_q;
    resched_d   = resched_q;
    loading_d   = loading_q;
    for_data_d  = for_data_q;
    n_d         = n_q;
    kidx_d      = kidx_q;
    acc_d       = acc_q;
    sn_d        = sn_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    byte_d      = byte_q;
    last_d      = last_q;
    out_data_d  = out_data_q;
    out_nk_d    = out_nk_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    perm_raddr  = n_q;
    perm_waddr  = n_q;
    perm_wdata  = n_q;
    perm_we     = 1'b0;
    key_waddr   = len_cur[KW-1:0];
    key_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          byte_d = s_axis_tdata_i;
          last_d = s_axis_tlast_i;
          if (s_axis_tuser_i == MODE_KEY) begin
            loading_d = 1'b1;
            key_len_d = len_cur;
            if (!loading_q) begin
              keyed_d   = 1'b0;
              resched_d = 1'b0;
            end
            if (len_cur < KEY_LEN_W'(KEY_BYTES_MAX)) begin
              key_we    = 1'b1;
              key_len_d = len_cur + KEY_LEN_W'(1);
            end
            if (s_axis_tlast_i) begin
              loading_d  = 1'b0;
              for_data_d = 1'b0;
              n_d        = '0;
              state_d    = ST_INIT;
            end
          end else if (!keyed_q) begin
            out_valid_d = 1'b1;
            out_data_d  = s_axis_tdata_i;
            out_nk_d    = 1'b1;
            out_last_d  = s_axis_tlast_i;
          end else if (resched_q) begin
            for_data_d = 1'b1;
            n_d        = '0;
            state_d    = ST_INIT;
          end else begin
            state_d = ST_D_RI;
          end
        end
      end
      // load the identity permutation
      ST_INIT: begin
        perm_we = 1'b1;
        n_d     = n_q + 8'd1;
        if (n_q == byte_t'(PERM_SIZE - 1)) begin
          acc_d   = '0;
          kidx_d  = '0;
          state_d = ST_K_RD;
        end
      end
      ST_K_RD: begin
        state_d = ST_K_ACC;
      end
      ST_K_ACC: begin
        perm_raddr = acc_sum;
        acc_d      = acc_sum;
        sn_d       = perm_rd_q;
        state_d    = ST_K_WA;
      end
      ST_K_WA: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rd_q;
        state_d    = ST_K_WB;
      end
      ST_K_WB: begin
        perm_we    = 1'b1;
        perm_waddr = acc_q;
        perm_wdata = sn_q;
        n_d        = n_q + 8'd1;
        // cycle through the stored key
        if ((KEY_LEN_W'(kidx_q) + KEY_LEN_W'(1)) == key_len_q) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KW'(1);
        end
        if (n_q == byte_t'(PERM_SIZE - 1)) begin
          i_d       = '0;
          j_d       = '0;
          resched_d = 1'b0;
          if (for_data_q) begin
            state_d = ST_D_RI;
          end else begin
            keyed_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_K_RD;
        end
      end
      ST_D_RI: begin
        perm_raddr = i_q + 8'd1;
        i_d        = i_q + 8'd1;
        state_d    = ST_D_RJ;
      end
      ST_D_RJ: begin
        perm_raddr = j_sum;
        j_d        = j_sum;
        si_d       = perm_rd_q;
        state_d    = ST_D_WI;
      end
      ST_D_WI: begin
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rd_q;
        perm_raddr = t_sum;
        sj_d       = perm_rd_q;
        t_d        = t_sum;
        state_d    = ST_D_WJ;
      end
      ST_D_WJ: begin
        perm_we     = 1'b1;
        perm_waddr  = j_q;
        perm_wdata  = si_q;
        out_valid_d = 1'b1;
        out_data_d  = byte_q ^ ks;
        out_nk_d    = 1'b0;
        out_last_d  = last_q;
        if (last_q) begin
          resched_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // permutation memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rd_q <= perm_mem[perm_raddr];
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= s_axis_tdata_i;
    end
    key_rd_q <= key_mem[kidx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_len_q   <= '0;
      keyed_q     <= 1'b0;
      resched_q   <= 1'b0;
      loading_q   <= 1'b0;
      for_data_q  <= 1'b0;
      n_q         <= '0;
      kidx_q      <= '0;
      acc_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_len_q   <= key_len_d;
      keyed_q     <= keyed_d;
      resched_q   <= resched_d;
      loading_q   <= loading_d;
      for_data_q  <= for_data_d;
      n_q         <= n_d;
      kidx_q      <= kidx_d;
      acc_q       <= acc_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sn_q       <= sn_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
    out_nk_q   <= out_nk_d;
    out_last_q <= out_last_d;
  end

endmodule : rc4_stream_cipher

FILE: tb/sv/tb_rc4_stream_cipher.sv
// Testbench for the RC4 stream cipher: directed table plus random key and message traffic.
`timescale 1ns / 100ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int unsigned KEY_BYTES_MAX = 256;
  localparam int unsigned RANDOM_ITEMS  = 320;

  // One output beat: byte_out, not_keyed, message_end.
  typedef struct packed {
    byte_t byte_out;
    logic  not_keyed;
    logic  message_end;
  } cipher_out_t;

  // One input beat. A directed row may carry its expected result directly.
  typedef struct packed {
    logic        mode;
    byte_t       byte_in;
    logic        last;
    logic        has_exp;
    cipher_out_t exp;
  } cipher_in_t;

  logic  clk_i;
  logic  rst_ni          = 1'b0;
  logic  s_axis_tvalid_i = 1'b0;
  byte_t s_axis_tdata_i  = '0;
  logic  s_axis_tuser_i  = 1'b0;
  logic  s_axis_tlast_i  = 1'b0;
  logic  m_axis_tready_i = 1'b0;
  logic  s_axis_tready_o;
  logic  m_axis_tvalid_o;
  byte_t m_axis_tdata_o;
  logic  m_axis_tuser_o;
  logic  m_axis_tlast_o;

  rc4_stream_cipher #(
    .KEY_BYTES_MAX(KEY_BYTES_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // [7:0] byte_in
    .s_axis_tuser_i (s_axis_tuser_i),   // [0] mode
    .s_axis_tlast_i (s_axis_tlast_i),   // last key byte / last message byte
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // [7:0] byte_out
    .m_axis_tuser_o (m_axis_tuser_o),   // [0] not_keyed
    .m_axis_tlast_o (m_axis_tlast_o)    // message_end
  );

  // ---------------------------------------------------------------------------
  // Cipher state mirrored by the testbench
  // ---------------------------------------------------------------------------
  byte_t       sbox [PERM_SIZE];
  byte_t       key_bytes [PERM_SIZE];
  int unsigned key_count;
  byte_t       idx_i;
  byte_t       idx_j;
  logic        have_key;
  logic        rekey_due;
  logic        key_open;

  cipher_out_t pending_cipher_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;

  // Identity permutation, then 256 swaps driven by the stored key (cycled).
  function automatic void run_key_schedule();
    int unsigned n;
    int unsigned len;
    byte_t       acc;
    byte_t       tmp;
    len = (key_count == 0 || key_count > PERM_SIZE) ? 1 : key_count;
    for (n = 0; n < PERM_SIZE; n++) sbox[n] = byte_t'(n);
    acc = '0;
    for (n = 0; n < PERM_SIZE; n++) begin
      acc = acc + sbox[n] + key_bytes[n % len];
      tmp = sbox[n];
      sbox[n] = sbox[acc];
      sbox[acc] = tmp;
    end
    idx_i     = '0;
    idx_j     = '0;
    rekey_due = 1'b0;
  endfunction

  // Advance the mirrored cipher by one input beat; returns 1 when a result is due.
  function automatic bit rc4_predict_byte(input cipher_in_t s, output cipher_out_t r);
    byte_t tmp;
    byte_t t;
    r = '0;
    if (s.mode == MODE_KEY) begin
      // first key byte after a completed key starts a fresh key
      if (!key_open) begin
        key_open  = 1'b1;
        key_count = 0;
        have_key  = 1'b0;
        rekey_due = 1'b0;
      end
      // drop bytes beyond the key store
      if (key_count < KEY_BYTES_MAX && key_count < PERM_SIZE) begin
        key_bytes[key_count] = s.byte_in;
        key_count++;
      end
      if (s.last) begin
        key_open = 1'b0;
        if (key_count > 0) begin
          run_key_schedule();
          have_key = 1'b1;
        end
      end
      return 1'b0;
    end
    r.message_end = s.last;
    if (!have_key) begin
      r.byte_out  = s.byte_in;
      r.not_keyed = 1'b1;
      return 1'b1;
    end
    if (rekey_due) run_key_schedule();
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    tmp = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    t = sbox[idx_i] + sbox[idx_j];
    r.byte_out  = s.byte_in ^ sbox[t];
    r.not_keyed = 1'b0;
    if (s.last) rekey_due = 1'b1;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, input driver with bursts and gaps, output stall pattern
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Present one beat at the falling edge, hold it until accepted, then predict.
  task automatic send_beat(input cipher_in_t s);
    cipher_out_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 32);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s.byte_in;
    s_axis_tuser_i  <= s.mode;
    s_axis_tlast_i  <= s.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (rc4_predict_byte(s, predicted))
      pending_cipher_bytes.push_back(s.has_exp ? s.exp : predicted);
  endtask

  // Receiver: switch between always-ready, rotating patterns and random stalls.
  int unsigned     stall_left = 0;
  int unsigned     stall_kind = 0;
  logic [15:0]     stall_pattern = '1;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind    = $urandom_range(0, 3);
      stall_left    = $urandom_range(16, 96);
      stall_pattern = 16'($urandom);
    end
    stall_left--;
    stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
    case (stall_kind)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= stall_pattern[0];
      2: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready_i <= stall_pattern[0] | stall_pattern[1];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output check against the oldest expected byte
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_out
    cipher_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_cipher_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected output beat byte_out=%h not_keyed=%b message_end=%b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        want = pending_cipher_bytes.pop_front();
        if (m_axis_tdata_o !== want.byte_out) begin
          mismatch_count++;
          $display("%0t: byte_out expected %h actual %h",
                   $time, want.byte_out, m_axis_tdata_o);
        end
        if (m_axis_tuser_o !== want.not_keyed) begin
          mismatch_count++;
          $display("%0t: not_keyed expected %b actual %b",
                   $time, want.not_keyed, m_axis_tuser_o);
        end
        if (m_axis_tlast_o !== want.message_end) begin
          mismatch_count++;
          $display("%0t: message_end expected %b actual %b",
                   $time, want.message_end, m_axis_tlast_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cipher_in_t  directed_rows[$];
    cipher_in_t  beat;
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    int unsigned random_items;

    key_count = 0;
    idx_i     = '0;
    idx_j     = '0;
    have_key  = 1'b0;
    rekey_due = 1'b0;
    key_open  = 1'b0;
    for (n = 0; n < PERM_SIZE; n++) begin
      sbox[n]      = '0;
      key_bytes[n] = '0;
    end

    // Directed table: mode, byte, last, has_exp, {byte_out, not_keyed, message_end}
    directed_rows = '{
      // data before any key passes through
      '{MODE_DATA, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{MODE_DATA, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{MODE_DATA, 8'hA5, 1'b0, 1'b1, '{8'hA5, 1'b1, 1'b0}},
      // three-byte key, then two messages; the second restarts the keystream
      '{MODE_KEY,  8'h4B, 1'b0, 1'b0, '0},
      '{MODE_KEY,  8'h65, 1'b0, 1'b0, '0},
      '{MODE_KEY,  8'h79, 1'b1, 1'b0, '0},
      '{MODE_DATA, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_DATA, 8'hFF, 1'b0, 1'b0, '0},
      '{MODE_DATA, 8'h5A, 1'b1, 1'b0, '0},
      '{MODE_DATA, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_DATA, 8'h3C, 1'b1, 1'b0, '0},
      // new key in progress: data passes through until the key completes
      '{MODE_KEY,  8'h00, 1'b0, 1'b0, '0},
      '{MODE_DATA, 8'h77, 1'b0, 1'b1, '{8'h77, 1'b1, 1'b0}},
      '{MODE_KEY,  8'hFF, 1'b1, 1'b0, '0},
      '{MODE_DATA, 8'h80, 1'b0, 1'b0, '0},
      '{MODE_DATA, 8'h01, 1'b1, 1'b0, '0},
      // single-byte key, two one-byte messages
      '{MODE_KEY,  8'h80, 1'b1, 1'b0, '0},
      '{MODE_DATA, 8'hC3, 1'b1, 1'b0, '0},
      '{MODE_DATA, 8'h3C, 1'b1, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) send_beat(directed_rows[k]);

    // Full-length key with last on the 256th byte, then a short message.
    // A 300-byte key follows whose last flag sits on a dropped byte.
    for (int unsigned klen = 256; klen <= 300; klen += 44) begin
      for (n = 0; n < klen; n++) begin
        beat = '{MODE_KEY, byte_t'($urandom), (n == klen - 1), 1'b0, '0};
        send_beat(beat);
      end
      for (n = 0; n < 4; n++) begin
        beat = '{MODE_DATA, byte_t'($urandom), (n == 3), 1'b0, '0};
        send_beat(beat);
      end
    end

    // Random traffic: mostly well-formed keys and messages, some noise and
    // broken sequences (data inside a key, stray key bytes, odd last flags).
    random_items = 0;
    pick = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items != 0) pick = $urandom_range(0, 99);
      if (pick < 12) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 300) : $urandom_range(1, 16);
        for (n = 0; n < len; n++) begin
          beat = '{MODE_KEY, byte_t'($urandom), (n == len - 1), 1'b0, '0};
          send_beat(beat);
          if (n < KEY_BYTES_MAX || n == len - 1) random_items++;
          // broken key: data slips in before the key completes
          if (n != len - 1 && $urandom_range(0, 19) == 0) begin
            beat = '{MODE_DATA, byte_t'($urandom), 1'($urandom), 1'b0, '0};
            send_beat(beat);
            random_items++;
          end
        end
      end else if (pick < 90) begin
        len = $urandom_range(1, 24);
        for (n = 0; n < len; n++) begin
          beat = '{MODE_DATA, byte_t'($urandom), (n == len - 1), 1'b0, '0};
          send_beat(beat);
          random_items++;
        end
      end else begin
        beat = '{($urandom_range(0, 3) == 0) ? MODE_KEY : MODE_DATA, byte_t'($urandom),
                 1'($urandom), 1'b0, '0};
        send_beat(beat);
        random_items++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    // Drain, then allow a little longer so a stray extra beat is caught.
    while (pending_cipher_bytes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
